### rtl/core/mebc_pkg.sv
`default_nettype none

package mebc_pkg;

  // fixed field widths of the request and response
  localparam int OP_W  = 3;
  localparam int IDX_W = 10;
  localparam int VAL_W = 64;
  localparam int CNT_W = 10;

  // request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_PEEK    = 3'd1,
    OP_HEAD    = 3'd2,
    OP_SET     = 3'd3,
    OP_REMOVE  = 3'd4,
    OP_COMPACT = 3'd5
  } op_e;

  // controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COMPACT
  } state_e;

  // access to the used-mark store
  typedef struct packed {
    logic wr;
    logic wbit;
    logic rd;
  } mark_cmd_t;

  // response loaded into the result stage
  typedef struct packed {
    logic             valid;
    logic             use_rdata;
    logic             status;
    logic [CNT_W-1:0] count;
  } rsp_load_t;

endpackage

`default_nettype wire

### rtl/core/mebc_if.sv
`default_nettype none

// request channel
interface mebc_req_if import mebc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [IDX_W-1:0] slot_index;
  logic [VAL_W-1:0] entry_value;

  modport source (output valid, operation, slot_index, entry_value, input ready);
  modport sink   (input valid, operation, slot_index, entry_value, output ready);
endinterface

// response channel
interface mebc_rsp_if import mebc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] read_value;
  logic [CNT_W-1:0] entry_count;
  logic             status;

  modport source (output valid, read_value, entry_count, status, input ready);
  modport sink   (input valid, read_value, entry_count, status, output ready);
endinterface

`default_nettype wire

### rtl/core/mebc_mark_store.sv
`default_nettype none

module mebc_mark_store import mebc_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire mark_cmd_t                cmd_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic                          rdata_o,
  output logic                          clr_busy_o
);

  localparam int AW = $clog2(DEPTH);

  logic          mem [DEPTH];
  logic          rdata_q;
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;
  logic          we;
  logic [AW-1:0] wa;
  logic          wb;

  // clearing sweep after reset, one entry per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // sweep owns the write port while busy
  always_comb begin
    if (clr_busy_q) begin
      we = 1'b1;
      wa = clr_addr_q;
      wb = 1'b0;
    end else begin
      we = cmd_i.wr;
      wa = waddr_i;
      wb = cmd_i.wbit;
    end
  end

  // mark memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wb;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o    = rdata_q;
  assign clr_busy_o = clr_busy_q;

endmodule

`default_nettype wire

### rtl/core/mebc_ctrl.sv
`default_nettype none

module mebc_ctrl import mebc_pkg::*; #(
  parameter int DEPTH       = 1024,
  parameter int ENTRY_WIDTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  mebc_req_if.sink                      req_i,
  input  wire logic                     clr_busy_i,
  output mark_cmd_t                     mark_cmd_o,
  output logic [$clog2(DEPTH)-1:0]      mark_waddr_o,
  output logic [$clog2(DEPTH)-1:0]      mark_raddr_o,
  input  wire logic                     mark_rdata_i,
  input  wire logic                     pend_busy_i,
  input  wire logic                     pend_free_i,
  output rsp_load_t                     load_o,
  output logic [VAL_W-1:0]              rdata_o
);

  localparam int AW    = $clog2(DEPTH);
  localparam int QMAX  = 1023 / DEPTH;
  localparam int STEPS = $clog2(QMAX + 1);

  state_e                 state_q, state_d;
  logic [AW-1:0]          count_q, count_d;
  logic [AW-1:0]          src_q, src_d;
  logic [AW-1:0]          dst_q, dst_d;
  logic                   rd_valid_q, rd_valid_d;
  logic [AW-1:0]          pos;
  logic [AW-1:0]          head;
  logic                   accept;
  logic                   issue;
  logic [AW+CNT_W-1:0]    cnt_ext;

  logic [ENTRY_WIDTH-1:0] ent_mem [DEPTH];
  logic [ENTRY_WIDTH-1:0] ent_rdata_q;
  logic                   ent_we;
  logic [AW-1:0]          ent_waddr;
  logic [ENTRY_WIDTH-1:0] ent_wdata;
  logic                   ent_re;
  logic [AW-1:0]          ent_raddr;

  // slot index reduced modulo depth by conditional subtraction
  always_comb begin
    logic [IDX_W-1:0] r;
    r = req_i.slot_index;
    for (int k = STEPS - 1; k >= 0; k--) begin
      if (32'(r) >= (DEPTH << k)) begin
        r = r - IDX_W'(DEPTH << k);
      end
    end
    pos = AW'(r);
  end

  // last entry, wrapping to the top on an empty buffer
  assign head = (count_q == '0) ? AW'(DEPTH - 1) : count_q - AW'(1);

  assign req_i.ready = (state_q == ST_IDLE) && pend_free_i;
  assign accept      = req_i.valid && req_i.ready;

  // next state, memory accesses and response load
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    src_d        = src_q;
    dst_d        = dst_q;
    rd_valid_d   = 1'b0;
    issue        = 1'b0;
    ent_we       = 1'b0;
    ent_waddr    = pos;
    ent_wdata    = req_i.entry_value[ENTRY_WIDTH-1:0];
    ent_re       = 1'b0;
    ent_raddr    = pos;
    mark_cmd_o   = '0;
    mark_waddr_o = pos;
    mark_raddr_o = src_q;
    load_o       = '0;

    case (state_q)
      ST_CLEAR: begin
        if (!clr_busy_i) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          load_o.valid = 1'b1;
          case (op_e'(req_i.operation))
            OP_PUSH: begin
              if (count_q == AW'(DEPTH - 1)) begin
                load_o.status = 1'b1;
              end else begin
                ent_we          = 1'b1;
                ent_waddr       = count_q;
                mark_cmd_o.wr   = 1'b1;
                mark_cmd_o.wbit = 1'b1;
                mark_waddr_o    = count_q;
                count_d         = count_q + AW'(1);
              end
            end
            OP_PEEK: begin
              ent_re           = 1'b1;
              load_o.use_rdata = 1'b1;
            end
            OP_HEAD: begin
              ent_re           = 1'b1;
              ent_raddr        = head;
              load_o.use_rdata = 1'b1;
            end
            OP_SET: begin
              ent_we          = 1'b1;
              mark_cmd_o.wr   = 1'b1;
              mark_cmd_o.wbit = 1'b1;
            end
            OP_REMOVE: begin
              mark_cmd_o.wr = 1'b1;
            end
            OP_COMPACT: begin
              load_o.valid = 1'b0;
              state_d      = ST_COMPACT;
              src_d        = '0;
              dst_d        = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_COMPACT: begin
        // read ahead at the source once the result stage is empty
        issue      = !pend_busy_i && (src_q != count_q);
        rd_valid_d = issue;
        if (issue) begin
          ent_re        = 1'b1;
          ent_raddr     = src_q;
          mark_cmd_o.rd = 1'b1;
          src_d         = src_q + AW'(1);
        end
        // used entry moves down to the destination
        if (rd_valid_q && mark_rdata_i) begin
          ent_we          = 1'b1;
          ent_waddr       = dst_q;
          ent_wdata       = ent_rdata_q;
          mark_cmd_o.wr   = 1'b1;
          mark_cmd_o.wbit = 1'b1;
          mark_waddr_o    = dst_q;
          dst_d           = dst_q + AW'(1);
        end
        // walk finished
        if ((src_q == count_q) && !rd_valid_q && pend_free_i) begin
          count_d      = dst_q;
          load_o.valid = 1'b1;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    cnt_ext      = {{CNT_W{1'b0}}, count_d};
    load_o.count = cnt_ext[CNT_W-1:0];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      count_q    <= '0;
      src_q      <= '0;
      dst_q      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      src_q      <= src_d;
      dst_q      <= dst_d;
      rd_valid_q <= rd_valid_d;
    end
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rdata_q <= ent_mem[ent_raddr];
    end
  end

  assign rdata_o = VAL_W'(ent_rdata_q);

endmodule

`default_nettype wire

### rtl/core/mebc_result.sv
`default_nettype none

module mebc_result import mebc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rsp_load_t        load_i,
  input  wire logic [VAL_W-1:0] rdata_i,
  output logic                  pend_busy_o,
  output logic                  pend_free_o,
  mebc_rsp_if.source            rsp_o
);

  logic             pend_q;
  rsp_load_t        pend_info_q;
  logic             out_valid_q;
  logic [VAL_W-1:0] out_value_q;
  logic [CNT_W-1:0] out_count_q;
  logic             out_status_q;
  logic             can_move;

  assign can_move    = !out_valid_q || rsp_o.ready;
  assign pend_busy_o = pend_q;
  assign pend_free_o = !pend_q || can_move;

  // pending slot waits for the memory read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i.valid) begin
        pend_q <= 1'b1;
      end else if (can_move) begin
        pend_q <= 1'b0;
      end
      if (pend_q && can_move) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload of pending slot and output register
  always_ff @(posedge clk_i) begin
    if (load_i.valid) begin
      pend_info_q <= load_i;
    end
    if (pend_q && can_move) begin
      out_value_q  <= pend_info_q.use_rdata ? rdata_i : '0;
      out_count_q  <= pend_info_q.count;
      out_status_q <= pend_info_q.status;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.read_value  = out_value_q;
  assign rsp_o.entry_count = out_count_q;
  assign rsp_o.status      = out_status_q;

endmodule

`default_nettype wire

### rtl/core/marked_entry_buffer_compactor_core.sv
`default_nettype none

// channel   dir  handshake      payload
// req_i     in   valid/ready    operation, slot_index, entry_value
// rsp_o     out  valid/ready    read_value, entry_count, status
//
// push, peek, peek head, set and remove take one request per cycle while the
// response side is not stalled; each response passes through the pending slot,
// which waits for the entry memory read, and then the output register.
// compact holds the request side through one memory read per entry below the
// count, then the result. after reset the used marks are swept clear; no
// request is taken until then. a stalled response holds the next request back
// after one more has been taken into the pending slot.

module marked_entry_buffer_compactor_core import mebc_pkg::*; #(
  parameter int DEPTH       = 1024,
  parameter int ENTRY_WIDTH = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mebc_req_if.sink   req_i,
  mebc_rsp_if.source rsp_o
);

  localparam int AW = $clog2(DEPTH);

  mark_cmd_t        mark_cmd;
  logic [AW-1:0]    mark_waddr;
  logic [AW-1:0]    mark_raddr;
  logic             mark_rdata;
  logic             clr_busy;
  logic             pend_busy;
  logic             pend_free;
  rsp_load_t        load;
  logic [VAL_W-1:0] rdata;

  // used-mark memory with clearing sweep
  mebc_mark_store #(
    .DEPTH (DEPTH)
  ) u_mark_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (mark_cmd),
    .waddr_i    (mark_waddr),
    .raddr_i    (mark_raddr),
    .rdata_o    (mark_rdata),
    .clr_busy_o (clr_busy)
  );

  // sequencer, count and entry memory
  mebc_ctrl #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .clr_busy_i   (clr_busy),
    .mark_cmd_o   (mark_cmd),
    .mark_waddr_o (mark_waddr),
    .mark_raddr_o (mark_raddr),
    .mark_rdata_i (mark_rdata),
    .pend_busy_i  (pend_busy),
    .pend_free_i  (pend_free),
    .load_o       (load),
    .rdata_o      (rdata)
  );

  // pending slot and output register
  mebc_result u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .rdata_i     (rdata),
    .pend_busy_o (pend_busy),
    .pend_free_o (pend_free),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire
